// ===== hw/rtl/itoar_pkg.sv =====
package itoar_pkg;

    // default word width of the converted integer
    localparam int WORD_BITS_DEF = 32;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0]  MINUS_CODE    = 7'd45;
    localparam logic [CHAR_W-1:0]  ZERO_CODE     = 7'd48;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT   = 6'd9;

    // quotient bits resolved per cycle by the divide loop
    localparam int STEP_BITS = 8;

    // depth of the queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_DIGIT
    } t_back_state;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] v;
        v = r;
        if (v < RADIX_MIN) begin
            v = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            v = RADIX_MAX;
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] v;
        v = {1'b0, d};
        if (d > DIGIT_LIMIT) begin
            v = v + LETTER_OFFSET;
        end else begin
            v = v + ZERO_CODE;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_radix_core.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+--------------------------------
// input     | in        | push / full               | i_value (WORD_BITS, signed)
// result    | out       | empty / pop               | o_out_char (7), o_last_char (1)
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_radix (6)
//
// Per number the back takes a queue entry and divides out each digit with a loop that
// resolves 8 quotient bits a cycle over the padded word, then emits a minus sign for a
// negative value and the digits most significant first.
// Reset (synchronous, active low) empties the queue and result register, idles the back.
// A two-entry queue parts the front from the back, so requests are taken while the back
// converts or stalls on pop; a held result only holds the back.
module integer_to_ascii_radix_core #(
    parameter int WORD_BITS = itoar_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input requests
    input  logic                          push,
    output logic                          full,
    input  logic [WORD_BITS-1:0]          i_value,
    // result characters
    output logic                          empty,
    input  logic                          pop,
    output logic [itoar_pkg::CHAR_W-1:0]  o_out_char,
    output logic                          o_last_char,
    // radix register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [itoar_pkg::RADIX_W-1:0] i_cfg_radix
);

    logic [itoar_pkg::RADIX_W-1:0] r_radix;
    logic                          q_push, q_pop, q_full, q_empty;
    logic [WORD_BITS:0]            q_wr_data, q_rd_data;

    // radix register: always ready, holds the written bits, resets to 10; clamping
    // happens at use
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itoar_pkg::RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radix <= i_cfg_radix;
        end
    end

    // front: take the request, split off the sign, form the unsigned magnitude
    itoar_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_push   (push),
        .o_full   (full),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wr_data)
    );

    // short queue of {sign, magnitude} between front and back
    itoar_queue #(
        .WIDTH (WORD_BITS + 1),
        .DEPTH (itoar_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    // back: divide out digits least significant first, then emit sign and digits
    // most significant first through a one-entry result register
    itoar_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (r_radix),
        .i_q_data    (q_rd_data),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

// ===== hw/rtl/itoar_front.sv =====
module itoar_front #(
    parameter int WORD_BITS = itoar_pkg::WORD_BITS_DEF
) (
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output logic [WORD_BITS:0]   o_q_data
);

    logic                 neg;
    logic [WORD_BITS-1:0] mag;

    // sign bit classifies; two's complement negate gives the unsigned magnitude
    assign neg = i_value[WORD_BITS-1];
    assign mag = neg ? (~i_value + 1'b1) : i_value;

    assign o_full   = i_q_full;
    assign o_q_push = i_push & ~i_q_full;
    assign o_q_data = {neg, mag};

endmodule

// ===== hw/rtl/itoar_queue.sv =====
module itoar_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = itoar_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = PTR_W'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = PTR_W'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/itoar_back.sv =====
module itoar_back #(
    parameter int WORD_BITS = itoar_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [itoar_pkg::RADIX_W-1:0] i_radix,
    input  logic [WORD_BITS:0]            i_q_data,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [itoar_pkg::CHAR_W-1:0]  o_out_char,
    output logic                          o_last_char
);

    localparam int STEP    = itoar_pkg::STEP_BITS;
    localparam int DIGIT_W = itoar_pkg::DIGIT_W;
    localparam int CHAR_W  = itoar_pkg::CHAR_W;
    localparam int CHUNKS  = (WORD_BITS + STEP - 1) / STEP;
    localparam int PAD_W   = CHUNKS * STEP;
    localparam int CNT_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int ND_W    = $clog2(WORD_BITS + 1);
    localparam int IDX_W   = $clog2(WORD_BITS);

    itoar_pkg::t_back_state r_state, n_state;

    logic                  r_neg, n_neg;
    logic [PAD_W-1:0]      r_div, n_div;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [DIGIT_W-1:0]    r_base, n_base;
    logic [CNT_W-1:0]      r_chunk, n_chunk;
    logic [ND_W-1:0]       r_nd, n_nd;
    logic [DIGIT_W-1:0]    r_digits [WORD_BITS];
    logic                  digit_we;

    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic [DIGIT_W-1:0]    step_rem;
    logic [PAD_W-1:0]      step_quo;
    logic                  out_free;
    logic [IDX_W-1:0]      rd_idx;

    // one chunk of restoring division: STEP quotient bits against the radix
    always_comb begin
        logic [DIGIT_W:0]   v_trial;
        logic [DIGIT_W-1:0] v_rem;
        logic [STEP-1:0]    v_top;
        logic [STEP-1:0]    v_q;
        v_top = r_div[PAD_W-1 -: STEP];
        v_rem = r_rem;
        v_q   = '0;
        for (int i = STEP - 1; i >= 0; i--) begin
            v_trial = {v_rem, v_top[i]};
            if (v_trial >= {1'b0, r_base}) begin
                v_rem  = DIGIT_W'(v_trial - {1'b0, r_base});
                v_q[i] = 1'b1;
            end else begin
                v_rem  = v_trial[DIGIT_W-1:0];
                v_q[i] = 1'b0;
            end
        end
        step_rem = v_rem;
        step_quo = (r_div << STEP) | PAD_W'(v_q);
    end

    assign out_free = ~r_out_valid | i_pop;
    assign rd_idx   = IDX_W'(r_nd - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_div       = r_div;
        n_rem       = r_rem;
        n_base      = r_base;
        n_chunk     = r_chunk;
        n_nd        = r_nd;
        n_out_valid = r_out_valid & ~i_pop;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        digit_we    = 1'b0;
        case (r_state)
            itoar_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_neg   = i_q_data[WORD_BITS];
                    n_div   = PAD_W'(i_q_data[WORD_BITS-1:0]);
                    n_base  = itoar_pkg::clamp_radix(i_radix);
                    n_rem   = '0;
                    n_chunk = '0;
                    n_nd    = '0;
                    n_state = itoar_pkg::BK_DIV;
                end
            end
            itoar_pkg::BK_DIV: begin
                n_div   = step_quo;
                n_rem   = step_rem;
                n_chunk = CNT_W'(r_chunk + 1'b1);
                if (r_chunk == CNT_W'(CHUNKS - 1)) begin
                    digit_we = 1'b1;
                    n_nd     = ND_W'(r_nd + 1'b1);
                    n_rem    = '0;
                    n_chunk  = '0;
                    if (step_quo == '0) begin
                        n_state = r_neg ? itoar_pkg::BK_SIGN : itoar_pkg::BK_DIGIT;
                    end
                end
            end
            itoar_pkg::BK_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itoar_pkg::MINUS_CODE;
                    n_out_last  = 1'b0;
                    n_state     = itoar_pkg::BK_DIGIT;
                end
            end
            itoar_pkg::BK_DIGIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itoar_pkg::digit_code(r_digits[rd_idx]);
                    n_out_last  = (r_nd == ND_W'(1));
                    n_nd        = ND_W'(r_nd - 1'b1);
                    if (r_nd == ND_W'(1)) begin
                        n_state = itoar_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = itoar_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itoar_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_base     <= n_base;
        r_chunk    <= n_chunk;
        r_nd       <= n_nd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        if (digit_we) begin
            r_digits[r_nd[IDX_W-1:0]] <= step_rem;
        end
    end

    assign o_empty     = ~r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule
